FILE: src/assert_macros.svh
// Assertion macros shared by the text renderer RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TMCR_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define TMCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/tmcr_pkg.sv
// Shared constants, command codes and interface structs of the text renderer.
// No dependencies; used by every module of the block.
`default_nettype none

package tmcr_pkg;

  // Store geometry. VRAM_BYTES must be a power of two.
  localparam int VRAM_BYTES = 16384;
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int BANK_AW    = VRAM_AW - 1;
  localparam int BANK_DEPTH = VRAM_BYTES / 2;
  localparam int FONT_DEPTH = 4096;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int PAL_DEPTH  = 16;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);
  localparam int RGB_W      = 24;

  // Timing and screen limits.
  localparam int BLINK_TICKS   = 500;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 400;

  // Command codes carried on in_tuser.
  localparam logic [2:0] CMD_VRAM_WR = 3'd0;
  localparam logic [2:0] CMD_FONT_WR = 3'd1;
  localparam logic [2:0] CMD_PAL_WR  = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_RENDER  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_VIDEO_MODE   = 3'd0;
  localparam logic [2:0] CFG_GRAPHIC_MODE = 3'd1;
  localparam logic [2:0] CFG_COLOUR_EN    = 3'd2;
  localparam logic [2:0] CFG_TEXT_COLUMNS = 3'd3;
  localparam logic [2:0] CFG_BUFFER_BASE  = 3'd4;
  localparam logic [2:0] CFG_CURSOR_COL   = 3'd5;
  localparam logic [2:0] CFG_CURSOR_ROW   = 3'd6;

  // Video memory access for one render word: text cell and cursor attribute.
  typedef struct packed {
    logic               we;
    logic [VRAM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [VRAM_AW-1:0] cell_addr;
    logic [VRAM_AW-1:0] cur_addr;
  } tmcr_vram_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic [7:0] cur_attr;
  } tmcr_vram_rsp_t;

endpackage

`default_nettype wire

FILE: src/tmcr_vram.sv
// Text video memory split into even and odd byte banks, one write and two reads each.
// Depends on tmcr_pkg for geometry and the request/response structs.
`default_nettype none

module tmcr_vram (
  input  logic                     clk,
  input  tmcr_pkg::tmcr_vram_req_t req,
  output tmcr_pkg::tmcr_vram_rsp_t rsp
);

  logic [7:0] even_mem [tmcr_pkg::BANK_DEPTH];
  logic [7:0] odd_mem  [tmcr_pkg::BANK_DEPTH];

  logic [tmcr_pkg::VRAM_AW-1:0] attr_addr;
  logic [tmcr_pkg::BANK_AW-1:0] even_cell_idx;
  logic [tmcr_pkg::BANK_AW-1:0] odd_cell_idx;
  logic [tmcr_pkg::BANK_AW-1:0] cur_idx;

  logic [7:0] even_cell_r;
  logic [7:0] odd_cell_r;
  logic [7:0] even_cur_r;
  logic [7:0] odd_cur_r;
  logic       cell_odd_r;
  logic       cur_odd_r;

  // Character and attribute always sit in opposite banks; the attribute
  // address wraps at the top of memory.
  assign attr_addr     = req.cell_addr + tmcr_pkg::VRAM_AW'(1);
  assign even_cell_idx = req.cell_addr[0] ? attr_addr[tmcr_pkg::VRAM_AW-1:1]
                                          : req.cell_addr[tmcr_pkg::VRAM_AW-1:1];
  assign odd_cell_idx  = req.cell_addr[tmcr_pkg::VRAM_AW-1:1];
  assign cur_idx       = req.cur_addr[tmcr_pkg::VRAM_AW-1:1];

  // Byte writes go to the bank picked by the address LSB.
  always_ff @(posedge clk) begin
    if (req.we) begin
      if (req.waddr[0]) begin
        odd_mem[req.waddr[tmcr_pkg::VRAM_AW-1:1]] <= req.wdata;
      end else begin
        even_mem[req.waddr[tmcr_pkg::VRAM_AW-1:1]] <= req.wdata;
      end
    end
  end

  // Registered reads: cell pair on the first port, cursor attribute on the second.
  always_ff @(posedge clk) begin
    if (req.re) begin
      even_cell_r <= even_mem[even_cell_idx];
      odd_cell_r  <= odd_mem[odd_cell_idx];
      even_cur_r  <= even_mem[cur_idx];
      odd_cur_r   <= odd_mem[cur_idx];
      cell_odd_r  <= req.cell_addr[0];
      cur_odd_r   <= req.cur_addr[0];
    end
  end

  assign rsp.ch       = cell_odd_r ? odd_cell_r : even_cell_r;
  assign rsp.attr     = cell_odd_r ? even_cell_r : odd_cell_r;
  assign rsp.cur_attr = cur_odd_r ? odd_cur_r : even_cur_r;

endmodule

`default_nettype wire

FILE: src/tmcr_font.sv
// Glyph row store, one byte per row, 16 rows per character, registered read.
// Depends on tmcr_pkg for its depth.
`default_nettype none

module tmcr_font (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tmcr_pkg::FONT_AW-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [tmcr_pkg::FONT_AW-1:0] raddr,
  output logic [7:0]                   rd_data
);

  logic [7:0] font_mem [tmcr_pkg::FONT_DEPTH];
  logic [7:0] rd_data_r;

  // One write and one read port; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      font_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= font_mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/tmcr_pal.sv
// 16-entry RGB palette with a registered read port.
// Depends on tmcr_pkg for its depth and color width.
`default_nettype none

module tmcr_pal (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tmcr_pkg::PAL_AW-1:0]  waddr,
  input  logic [tmcr_pkg::RGB_W-1:0]   wdata,
  input  logic                         re,
  input  logic [tmcr_pkg::PAL_AW-1:0]  raddr,
  output logic [tmcr_pkg::RGB_W-1:0]   rd_data
);

  logic [tmcr_pkg::RGB_W-1:0] pal_mem [tmcr_pkg::PAL_DEPTH];
  logic [tmcr_pkg::RGB_W-1:0] rd_data_r;

  // Palette writes and lookups, read data held while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      pal_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= pal_mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/text_mode_character_renderer.sv
// Text mode character renderer: top level, render pipeline and configuration.
// A render word passes the stage 1, stage 2 and output registers before it shows on out_tvalid.
// Throughput: one word per cycle while out_tready is high; each stage holds one word and moves on when the
// next is free, so in_tready stays high while the pipeline has an empty slot.
// Reset clears the configuration, blink state and valid flags; the stores have none.
// Uses tmcr_pkg, tmcr_vram, tmcr_font, tmcr_pal and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module text_mode_character_renderer (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: target_index[13:0], write_value[37:14], pixel_x[47:38], pixel_y[56:48]
  input  logic [63:0] in_tdata,
  // tuser: command[2:0]
  input  logic [2:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: pixel_rgb[23:0]
  output logic [23:0] out_tdata,
  // tuser: pixel_changed[0]
  output logic        out_tuser,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [13:0] cfg_wdata
);

  localparam int SUM_W = 17;

  // Text modes, cursor scan lines and monochrome palette slots.
  localparam logic [7:0] MODE_T40_BW  = 8'd0;
  localparam logic [7:0] MODE_T40_COL = 8'd1;
  localparam logic [7:0] MODE_T80_BW  = 8'd2;
  localparam logic [7:0] MODE_T80_COL = 8'd3;
  localparam logic [7:0] MODE_MONO    = 8'd7;
  localparam logic [2:0] CURSOR_LINES = 3'b110;
  localparam logic [7:0] ATTR_REVERSE = 8'h70;
  localparam logic [3:0] PAL_DARK     = 4'd0;
  localparam logic [3:0] PAL_LIGHT    = 4'd7;

  // Configuration registers
  logic [7:0]  video_mode_r;
  logic        graphic_mode_r;
  logic        colour_enable_r;
  logic [6:0]  text_columns_r;
  logic [13:0] buffer_base_r;
  logic [6:0]  cursor_col_r;
  logic [4:0]  cursor_row_r;

  // Blink state
  logic [8:0]  blink_count_r;
  logic [8:0]  blink_count_nxt;
  logic        cursor_shown_r;
  logic        cursor_shown_nxt;
  logic [8:0]  blink_inc;

  // Input word fields
  logic [2:0]  in_cmd;
  logic [13:0] in_idx;
  logic [23:0] in_val;
  logic [9:0]  in_px;
  logic [8:0]  in_py;
  logic        in_acc;
  logic        tick_acc;

  // Render stage 0
  logic [4:0]             cell_row;
  logic [6:0]             cell_col;
  logic                   on_screen;
  logic                   text_mode;
  logic                   text_hit;
  logic                   cur_hit;
  logic [11:0]            cell_off;
  logic [11:0]            cur_off;
  logic [SUM_W-1:0]       cell_sum;
  logic [SUM_W-1:0]       cur_sum;
  tmcr_pkg::tmcr_vram_req_t vram_req;
  tmcr_pkg::tmcr_vram_rsp_t vram_rsp;

  // Stage 1
  logic        s1_v_r;
  logic [2:0]  s1_cmd_r;
  logic [11:0] s1_idx_r;
  logic [23:0] s1_val_r;
  logic [3:0]  s1_frow_r;
  logic [2:0]  s1_fbit_r;
  logic        s1_text_r;
  logic        s1_cur_r;

  // Stage 2
  logic        s2_v_r;
  logic [2:0]  s2_cmd_r;
  logic [3:0]  s2_idx_r;
  logic [23:0] s2_val_r;
  logic [2:0]  s2_fbit_r;
  logic [7:0]  s2_attr_r;
  logic [3:0]  s2_cur_attr_r;
  logic        s2_text_r;
  logic        s2_cur_r;
  logic [7:0]  font_q;
  logic        fg;
  logic [3:0]  pal_idx;

  // Output stage
  logic        out_v_r;
  logic        out_draw_r;
  logic [23:0] pal_q;

  // Stage enables
  logic en_out;
  logic en2;

  assign en_out    = !out_v_r || out_tready;
  assign en2       = !s2_v_r || en_out;
  assign in_tready = !s1_v_r || en2;
  assign in_acc    = in_tvalid && in_tready;

  assign in_cmd = in_tuser;
  assign in_idx = in_tdata[13:0];
  assign in_val = in_tdata[37:14];
  assign in_px  = in_tdata[47:38];
  assign in_py  = in_tdata[56:48];

  assign tick_acc = in_acc && (in_cmd == tmcr_pkg::CMD_TICK);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_mode_r    <= MODE_T80_COL;
      graphic_mode_r  <= 1'b0;
      colour_enable_r <= 1'b1;
      text_columns_r  <= 7'd80;
      buffer_base_r   <= 14'd0;
      cursor_col_r    <= 7'd0;
      cursor_row_r    <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tmcr_pkg::CFG_VIDEO_MODE:   video_mode_r    <= cfg_wdata[7:0];
        tmcr_pkg::CFG_GRAPHIC_MODE: graphic_mode_r  <= cfg_wdata[0];
        tmcr_pkg::CFG_COLOUR_EN:    colour_enable_r <= cfg_wdata[0];
        tmcr_pkg::CFG_TEXT_COLUMNS: text_columns_r  <= cfg_wdata[6:0];
        tmcr_pkg::CFG_BUFFER_BASE:  buffer_base_r   <= cfg_wdata;
        tmcr_pkg::CFG_CURSOR_COL:   cursor_col_r    <= cfg_wdata[6:0];
        tmcr_pkg::CFG_CURSOR_ROW:   cursor_row_r    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Millisecond ticks toggle the cursor when the count reaches its period.
  assign blink_inc = blink_count_r + 9'd1;

  always_comb begin
    blink_count_nxt  = blink_count_r;
    cursor_shown_nxt = cursor_shown_r;
    if (tick_acc) begin
      if (blink_inc >= 9'(tmcr_pkg::BLINK_TICKS)) begin
        blink_count_nxt  = 9'd0;
        cursor_shown_nxt = !cursor_shown_r;
      end else begin
        blink_count_nxt = blink_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_count_r  <= 9'd0;
      cursor_shown_r <= 1'b0;
    end else begin
      blink_count_r  <= blink_count_nxt;
      cursor_shown_r <= cursor_shown_nxt;
    end
  end

  // Stage 0: map the pixel to its cell and decide text and cursor coverage.
  assign cell_row  = in_py[8:4];
  assign cell_col  = in_px[9:3];
  assign on_screen = (in_px < 10'(tmcr_pkg::SCREEN_WIDTH)) &&
                     (in_py < 9'(tmcr_pkg::SCREEN_HEIGHT));

  always_comb begin
    case (video_mode_r) inside
      MODE_T40_BW, MODE_T40_COL, MODE_T80_BW, MODE_T80_COL, MODE_MONO: text_mode = 1'b1;
      default: text_mode = 1'b0;
    endcase
  end

  assign text_hit = on_screen && text_mode;
  assign cur_hit  = on_screen && !graphic_mode_r && cursor_shown_r &&
                    (cell_row == cursor_row_r) && (cell_col == cursor_col_r) &&
                    (in_py[3:1] == CURSOR_LINES);

  // Cell byte addresses; the cursor address is the attribute byte of its cell.
  assign cell_off = 12'(cell_row) * 12'(text_columns_r);
  assign cur_off  = 12'(cursor_row_r) * 12'(text_columns_r);
  assign cell_sum = SUM_W'(buffer_base_r) + SUM_W'({(13'(cell_off) + 13'(cell_col)), 1'b0});
  assign cur_sum  = SUM_W'(buffer_base_r) + SUM_W'({(13'(cur_off) + 13'(cursor_col_r)), 1'b0})
                    + SUM_W'(1);

  always_comb begin
    vram_req.we        = in_acc && (in_cmd == tmcr_pkg::CMD_VRAM_WR);
    vram_req.waddr     = tmcr_pkg::VRAM_AW'(in_idx);
    vram_req.wdata     = in_val[7:0];
    vram_req.re        = in_acc && (in_cmd == tmcr_pkg::CMD_RENDER);
    vram_req.cell_addr = cell_sum[tmcr_pkg::VRAM_AW-1:0];
    vram_req.cur_addr  = cur_sum[tmcr_pkg::VRAM_AW-1:0];
  end

  tmcr_vram u_vram (
    .clk (clk),
    .req (vram_req),
    .rsp (vram_rsp)
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_cmd_r  <= in_cmd;
      s1_idx_r  <= in_idx[11:0];
      s1_val_r  <= in_val;
      s1_frow_r <= in_py[3:0];
      s1_fbit_r <= in_px[2:0];
      s1_text_r <= text_hit;
      s1_cur_r  <= cur_hit;
    end
  end

  // Stage 1: glyph row fetch; font writes land here to keep word order.
  tmcr_font u_font (
    .clk     (clk),
    .we      (en2 && s1_v_r && (s1_cmd_r == tmcr_pkg::CMD_FONT_WR)),
    .waddr   (s1_idx_r[tmcr_pkg::FONT_AW-1:0]),
    .wdata   (s1_val_r[7:0]),
    .re      (en2 && s1_v_r && (s1_cmd_r == tmcr_pkg::CMD_RENDER)),
    .raddr   ({vram_rsp.ch, s1_frow_r}),
    .rd_data (font_q)
  );

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd_r      <= s1_cmd_r;
      s2_idx_r      <= s1_idx_r[3:0];
      s2_val_r      <= s1_val_r;
      s2_fbit_r     <= s1_fbit_r;
      s2_attr_r     <= vram_rsp.attr;
      s2_cur_attr_r <= vram_rsp.cur_attr[3:0];
      s2_text_r     <= s1_text_r;
      s2_cur_r      <= s1_cur_r;
    end
  end

  // Stage 2: pick the palette slot; the cursor overrides the text color.
  always_comb begin
    fg = font_q[~s2_fbit_r];
    if (s2_cur_r) begin
      pal_idx = s2_cur_attr_r;
    end else if (colour_enable_r) begin
      pal_idx = fg ? s2_attr_r[3:0] : s2_attr_r[7:4];
    end else if ((s2_attr_r & ATTR_REVERSE) != 8'd0) begin
      pal_idx = fg ? PAL_DARK : PAL_LIGHT;
    end else begin
      pal_idx = fg ? PAL_LIGHT : PAL_DARK;
    end
  end

  tmcr_pal u_pal (
    .clk     (clk),
    .we      (en_out && s2_v_r && (s2_cmd_r == tmcr_pkg::CMD_PAL_WR)),
    .waddr   (s2_idx_r),
    .wdata   (s2_val_r),
    .re      (en_out && s2_v_r && (s2_cmd_r == tmcr_pkg::CMD_RENDER)),
    .raddr   (pal_idx),
    .rd_data (pal_q)
  );

  // Output register: only render words produce a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s2_v_r && (s2_cmd_r == tmcr_pkg::CMD_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_draw_r <= s2_text_r || s2_cur_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_draw_r ? pal_q : 24'd0;
  assign out_tuser  = out_draw_r;

  // Checks
  `TMCR_ASSERT(a_blink_range, blink_count_r < 9'(tmcr_pkg::BLINK_TICKS), "blink count out of range")
  `TMCR_ASSERT_IMP(a_ready_free_slot, !s1_v_r, in_tready, "ready low with stage 1 empty")
  `TMCR_ASSERT_IMP(a_blank_pixel, out_tvalid && !out_tuser, out_tdata == 24'd0, "undrawn pixel not zero")
  `TMCR_ASSERT_IMP(a_cursor_on_tick, $past(rst_n) && (cursor_shown_r != $past(cursor_shown_r)), $past(tick_acc), "cursor toggled without tick")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the text mode character renderer: streams commands in,
// predicts every rendered pixel and compares the result words as they come out.
// Depends on tmcr_pkg and the RTL of text_mode_character_renderer only.

module testbench;
  import tmcr_pkg::*;

  // Character cell geometry and attribute decoding.
  localparam int GLYPH_W      = 8;
  localparam int GLYPH_H      = 16;
  localparam int CURSOR_TOP   = 12;
  localparam int CURSOR_H     = 2;
  localparam logic [7:0] REVERSE_MASK = 8'h70;
  localparam int PAL_DARK     = 0;
  localparam int PAL_LIGHT    = 7;
  localparam logic [2:0] CMD_LAST = 3'd7;

  // Run shape.
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] data;
  } cmd_word_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        drawn;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [13:0] cfg_wdata = '0;

  text_mode_character_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // tdata: target_index[13:0], write_value[37:14], pixel_x[47:38], pixel_y[56:48]
    .in_tdata   (in_tdata),
    // tuser: command[2:0]
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // tdata: pixel_rgb[23:0]
    .out_tdata  (out_tdata),
    // tuser: pixel_changed[0]
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting to be sent and pixels waiting to come back.
  cmd_word_t cmd_words_q[$];
  pixel_t    pixel_expect_q[$];

  // Display settings as last programmed; shared by the predictor and the generator.
  int vmode = 3;
  bit gfx_on = 1'b0;
  bit colour_on = 1'b1;
  int row_cells = 80;
  int text_base = 0;
  int cur_col = 0;
  int cur_row = 0;

  // Predicted contents of the block's stores and blink state.
  logic [7:0]  vram_img [VRAM_BYTES];
  logic [7:0]  font_img [FONT_DEPTH];
  logic [23:0] pal_img  [PAL_DEPTH];
  int          blink_cnt = 0;
  bit          cursor_on = 1'b0;

  // Generator's view of what has been queued so far.
  bit [7:0] gen_vram [VRAM_BYTES];
  bit       vram_set [VRAM_BYTES];
  bit       font_set [FONT_DEPTH];
  int       gen_ticks = 0;

  bit     calm = 1'b0;
  int     fault_count = 0;
  int     results_seen = 0;
  int     quiet_cycles = 0;
  int     send_gap = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  pixel_t want;

  // Per-phase display settings: mode, graphic, colour, columns, base, cursor col, row.
  int phase_cfg [PHASES][7] = '{
    '{3,   0, 1, 80, 0,     0,   0},
    '{7,   0, 0, 80, 16383, 79,  24},
    '{0,   0, 1, 1,  16000, 5,   3},
    '{255, 0, 1, 40, 200,   10,  10},
    '{2,   0, 0, 47, 8192,  40,  12},
    '{3,   1, 1, 80, 100,   20,  5},
    '{7,   0, 1, 64, 300,   127, 31},
    '{1,   0, 1, 80, 0,     0,   0}
  };
  bit cursor_want [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1};

  function automatic int cell_offset(int r, int c);
    return (text_base + (r * row_cells + c) * 2) % VRAM_BYTES;
  endfunction

  // Update the predicted state with one accepted word; renders queue a pixel.
  function automatic void absorb_word(logic [2:0] cmd, logic [63:0] data);
    logic [13:0] idx;
    logic [23:0] val;
    int          px, py, a, top, left;
    logic [7:0]  ch, attr, glyph;
    logic        lit;
    pixel_t      pix;
    idx = data[13:0];
    val = data[37:14];
    px  = data[47:38];
    py  = data[56:48];
    case (cmd)
      CMD_VRAM_WR: vram_img[idx] = val[7:0];
      CMD_FONT_WR: font_img[idx[FONT_AW-1:0]] = val[7:0];
      CMD_PAL_WR:  pal_img[idx[PAL_AW-1:0]] = val;
      CMD_TICK: begin
        blink_cnt = (blink_cnt + 1) & 'h1FF;
        if (blink_cnt >= BLINK_TICKS) begin
          blink_cnt = 0;
          cursor_on = !cursor_on;
        end
      end
      CMD_RENDER: begin
        pix = '0;
        if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
          // Text layer: glyph bit picks foreground or background.
          if (vmode <= 3 || vmode == 7) begin
            a     = cell_offset(py / GLYPH_H, px / GLYPH_W);
            ch    = vram_img[a];
            attr  = vram_img[(a + 1) % VRAM_BYTES];
            glyph = font_img[(ch * GLYPH_H + py % GLYPH_H) % FONT_DEPTH];
            lit   = glyph[GLYPH_W - 1 - px % GLYPH_W];
            if (colour_on)
              pix.rgb = lit ? pal_img[attr[3:0]] : pal_img[attr[7:4]];
            else if ((attr & REVERSE_MASK) != 0)
              pix.rgb = lit ? pal_img[PAL_DARK] : pal_img[PAL_LIGHT];
            else
              pix.rgb = lit ? pal_img[PAL_LIGHT] : pal_img[PAL_DARK];
            pix.drawn = 1'b1;
          end
          // Cursor bar takes the foreground color of its own cell.
          if (!gfx_on && cursor_on) begin
            top  = cur_row * GLYPH_H + CURSOR_TOP;
            left = cur_col * GLYPH_W;
            if (py >= top && py < top + CURSOR_H && px >= left && px < left + GLYPH_W) begin
              attr      = vram_img[(cell_offset(cur_row, cur_col) + 1) % VRAM_BYTES];
              pix.rgb   = pal_img[attr[3:0]];
              pix.drawn = 1'b1;
            end
          end
        end
        pixel_expect_q.push_back(pix);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_word(logic [2:0] cmd, logic [13:0] idx, logic [23:0] val,
                                     logic [9:0] px, logic [8:0] py);
    cmd_word_t w;
    w.cmd  = cmd;
    w.data = {7'd0, py, px, val, idx};
    cmd_words_q.push_back(w);
    if (cmd == CMD_VRAM_WR) begin
      gen_vram[idx] = val[7:0];
      vram_set[idx] = 1'b1;
    end
    if (cmd == CMD_FONT_WR)
      font_set[idx[FONT_AW-1:0]] = 1'b1;
    if (cmd == CMD_TICK)
      gen_ticks++;
  endfunction

  // Stores have no reset: write an entry before anything can read it.
  function automatic void need_vram(int a);
    if (!vram_set[a])
      queue_word(CMD_VRAM_WR, a, $urandom, $urandom, $urandom);
  endfunction

  function automatic void need_font(int i);
    if (!font_set[i])
      queue_word(CMD_FONT_WR, i | ($urandom_range(0, 3) << FONT_AW), $urandom,
                 $urandom, $urandom);
  endfunction

  function automatic void queue_render(int px, int py);
    int a;
    if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
      a = cell_offset(py / GLYPH_H, px / GLYPH_W);
      need_vram(a);
      need_vram((a + 1) % VRAM_BYTES);
      need_font(gen_vram[a] * GLYPH_H + py % GLYPH_H);
    end
    queue_word(CMD_RENDER, $urandom, $urandom, px, py);
  endfunction

  // Run ticks until the blink state shows or hides the cursor as asked.
  function automatic void steer_cursor(bit shown);
    if (((gen_ticks / BLINK_TICKS) % 2) != shown)
      repeat (BLINK_TICKS - gen_ticks % BLINK_TICKS)
        queue_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void queue_random_word();
    int pick, sel, px, py, a;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        // Around the cursor bar, one pixel beyond each edge.
        px = cur_col * GLYPH_W + $urandom_range(0, GLYPH_W + 1) - 1;
        py = cur_row * GLYPH_H + CURSOR_TOP - 1 + $urandom_range(0, CURSOR_H + 1);
        if (px < 0) px = 0;
        if (px > 1023) px = 1023;
      end else if (sel < 25) begin
        px = $urandom_range(0, 1023);
        py = $urandom_range(0, 511);
      end else if (sel < 70) begin
        px = $urandom_range(0, 10 * GLYPH_W - 1);
        py = $urandom_range(0, 3 * GLYPH_H - 1);
      end else begin
        px = $urandom_range(0, SCREEN_WIDTH - 1);
        py = $urandom_range(0, SCREEN_HEIGHT - 1);
      end
      queue_render(px, py);
    end else if (pick < 72) begin
      if ($urandom_range(0, 1))
        a = cell_offset($urandom_range(0, 2), $urandom_range(0, 9)) + $urandom_range(0, 1);
      else
        a = $urandom_range(0, VRAM_BYTES - 1);
      queue_word(CMD_VRAM_WR, a, $urandom, $urandom, $urandom);
    end else if (pick < 82) begin
      if ($urandom_range(0, 1))
        a = gen_vram[cell_offset($urandom_range(0, 2), $urandom_range(0, 9))] * GLYPH_H
            + $urandom_range(0, GLYPH_H - 1);
      else
        a = $urandom;
      queue_word(CMD_FONT_WR, a, $urandom, $urandom, $urandom);
    end else if (pick < 88) begin
      queue_word(CMD_PAL_WR, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 96) begin
      queue_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
    end else begin
      queue_word($urandom_range(CMD_RENDER + 1, CMD_LAST), $urandom, $urandom,
                 $urandom, $urandom);
    end
  endfunction

  function automatic void queue_directed();
    // Full palette, black and white at the ends, last entry through a wide index.
    for (int i = 0; i < PAL_DEPTH; i++)
      queue_word(CMD_PAL_WR, (i == PAL_DEPTH - 1) ? 14'h3FFF : i,
                 (i == 0) ? 24'h0 : (i == PAL_DEPTH - 1) ? 24'hFFFFFF : $urandom,
                 $urandom, $urandom);
    // Wide indexes and values that get folded into the stores.
    queue_word(CMD_FONT_WR, 14'h3FFF, 24'hFFFFFF, 10'h3FF, 9'h1FF);
    queue_word(CMD_VRAM_WR, 14'h3FFF, 24'hFFFFA5, 10'h3FF, 9'h1FF);
    // Screen corners, a second pixel of the first cell, and pixels off screen.
    queue_render(0, 0);
    queue_render(GLYPH_W - 1, GLYPH_H - 1);
    queue_render(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    queue_render(SCREEN_WIDTH, 0);
    queue_render(0, SCREEN_HEIGHT);
    queue_render(1023, 511);
    queue_word(CMD_TICK, 14'h0, 24'h0, 10'h0, 9'h0);
    // Unused command codes are dropped.
    for (int c = CMD_RENDER + 1; c <= CMD_LAST; c++)
      queue_word(c, 14'h3FFF, 24'hFFFFFF, 10'h3FF, 9'h1FF);
  endfunction

  // Write all seven registers, one per cycle, while the block is idle.
  task automatic program_display(input int mode, input int gfx, input int colour,
                                 input int cols, input int base, input int ccol,
                                 input int crow);
    int         vals [7];
    logic [2:0] regs [7];
    vals = '{mode, gfx, colour, cols, base, ccol, crow};
    regs = '{CFG_VIDEO_MODE, CFG_GRAPHIC_MODE, CFG_COLOUR_EN, CFG_TEXT_COLUMNS,
             CFG_BUFFER_BASE, CFG_CURSOR_COL, CFG_CURSOR_ROW};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    vmode     = mode & 'hFF;
    gfx_on    = gfx & 1;
    colour_on = colour & 1;
    row_cells = cols & 'h7F;
    text_base = base & 'h3FFF;
    cur_col   = ccol & 'h7F;
    cur_row   = crow & 'h1F;
  endtask

  // Wait until every word is sent and every pixel is back, then let the pipe drain.
  task automatic settle();
    while (cmd_words_q.size() != 0 || pixel_expect_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void log_fault(string why, logic [23:0] exp_rgb, logic exp_drawn);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected rgb %06h changed %0b, got rgb %06h changed %0b",
               why, exp_rgb, exp_drawn, out_tdata, out_tuser);
  endfunction

  // Sender: holds each word until it is taken, with random gaps between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready)
        void'(cmd_words_q.pop_front());
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (cmd_words_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= cmd_words_q[0].data;
          in_tuser  <= cmd_words_q[0].cmd;
          if (!calm && $urandom_range(0, 99) < 6)
            send_gap <= $urandom_range(1, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: short random stalls, and one long hold-off to back up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 5) begin
      stall_left <= $urandom_range(1, 10) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict from accepted command words, then check returned pixel words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        absorb_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (pixel_expect_q.size() == 0) begin
          log_fault("pixel word with nothing expected", 'x, 1'bx);
        end else begin
          want = pixel_expect_q.pop_front();
          if (want.rgb !== out_tdata || want.drawn !== out_tuser)
            log_fault("pixel mismatch", want.rgb, want.drawn);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    need_vram((cell_offset(cur_row, cur_col) + 1) % VRAM_BYTES);
    queue_directed();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == PHASES - 1)
        program_display($urandom_range(0, 7), 0, $urandom_range(0, 1),
                        $urandom_range(1, 80), $urandom_range(0, VRAM_BYTES - 1),
                        $urandom_range(0, 79), $urandom_range(0, 24));
      else
        program_display(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                        phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5],
                        phase_cfg[p][6]);
      @(negedge clk);
      // The closing phase runs without idling on either side.
      if (p == PHASES - 1)
        calm = 1'b1;
      need_vram((cell_offset(cur_row, cur_col) + 1) % VRAM_BYTES);
      steer_cursor(cursor_want[p]);
      repeat (PHASE_WORDS) queue_random_word();
    end
    settle();
    fault_count += pixel_expect_q.size();
    if (fault_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
